// File: rtl/core/chime_tone_and_light_averager_unit_assert.svh
// Assertion macros shared by the chime and light averager RTL.
`ifndef CHIME_TONE_AND_LIGHT_AVERAGER_UNIT_ASSERT_SVH
`define CHIME_TONE_AND_LIGHT_AVERAGER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define CTLA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define CTLA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ctla_pkg.sv
// Shared constants, types and helper functions of the chime and light averager.
package ctla_pkg;

    // Light window geometry.
    localparam int WINDOW      = 40;
    localparam int SAMPLE_BITS = 12;
    localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W      = $clog2(WINDOW + 1);
    localparam int SUM_W       = SAMPLE_BITS + FILL_W;

    // Register and field widths.
    localparam int STEP_W   = 10;
    localparam int LEN_W    = 3;
    localparam int WORD_W   = 10;
    localparam int THR_W    = 12;
    localparam int COUNT_W  = 11;
    localparam int WIDX_W   = 2;
    localparam int DAC_W    = 10;
    localparam int PROD_W   = WORD_W + STEP_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int CMP_W    = ((SUM_W > THR_W + FILL_W) ? SUM_W : THR_W + FILL_W) + 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TAPER_STEPS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_LENGTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_WORD_A     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_WORD_B     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_WORD_C     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_WORD_D     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_THRESHOLD = 3'd6;

    // Register reset values.
    localparam logic [STEP_W-1:0] RST_TAPER_STEPS     = 10'd900;
    localparam logic [LEN_W-1:0]  RST_WAVE_LENGTH     = 3'd4;
    localparam logic [WORD_W-1:0] RST_WAVE_WORD_A     = 10'd512;
    localparam logic [WORD_W-1:0] RST_WAVE_WORD_B     = 10'd1023;
    localparam logic [WORD_W-1:0] RST_WAVE_WORD_C     = 10'd0;
    localparam logic [WORD_W-1:0] RST_WAVE_WORD_D     = 10'd512;
    localparam logic [THR_W-1:0]  RST_LIGHT_THRESHOLD = 12'd1638;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    // Wave table slot in use: index modulo the clamped table length.
    function automatic logic [WIDX_W-1:0] wave_slot(input logic [WIDX_W-1:0] index,
                                                    input logic [LEN_W-1:0]  length);
        logic [WIDX_W-1:0] slot;
        begin
            case (length)
                3'd0, 3'd1: slot = 2'd0;
                3'd2:       slot = {1'b0, index[0]};
                3'd3:       slot = (index == 2'd3) ? 2'd0 : index;
                default:    slot = index;
            endcase
            return slot;
        end
    endfunction

endpackage

// File: rtl/core/ctla_in_if.sv
// Request channel carrying one tick of button level and light sample.
interface ctla_in_if;
    logic                            valid;
    logic                            ready;
    logic                            button;
    logic [ctla_pkg::SAMPLE_BITS-1:0] light_sample;

    modport source (output valid, output button, output light_sample, input ready);
    modport sink   (input valid, input button, input light_sample, output ready);
endinterface

// File: rtl/core/ctla_out_if.sv
// Result channel carrying the converter sample, LED level and period choice.
interface ctla_out_if;
    logic                      valid;
    logic                      ready;
    logic                      dac_write;
    logic [ctla_pkg::DAC_W-1:0] dac_value;
    logic                      led_on;
    logic                      wait_select;

    modport source (output valid, output dac_write, output dac_value, output led_on,
                    output wait_select, input ready);
    modport sink   (input valid, input dac_write, input dac_value, input led_on,
                    input wait_select, output ready);
endinterface

// File: rtl/core/ctla_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ctla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/ctla_taper_div.sv
// Bit-serial restoring divider that scales a wave word by the taper fraction.
module ctla_taper_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ctla_pkg::PROD_W-1:0]   i_dividend,
    input  logic [ctla_pkg::STEP_W-1:0]   i_divisor,
    output logic [ctla_pkg::DAC_W-1:0]    o_quotient,
    output ctla_pkg::t_div_status         o_status
);

    localparam int CNT_W = $clog2(ctla_pkg::DAC_W + 1);

    logic [ctla_pkg::STEP_W-1:0] r_rem;
    logic [ctla_pkg::DAC_W-1:0]  r_low;
    logic [ctla_pkg::STEP_W-1:0] r_div;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [ctla_pkg::STEP_W:0]   n_trial;
    logic [ctla_pkg::STEP_W:0]   n_diff;
    logic                        n_ge;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    // The quotient is known to fit in DAC_W bits, so the upper half starts below the divisor.
    always_comb begin
        n_trial = {r_rem, r_low[ctla_pkg::DAC_W-1]};
        n_diff  = n_trial - {1'b0, r_div};
        n_ge    = (n_trial >= {1'b0, r_div});
    end

    // Control: busy while the quotient bits are formed, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(ctla_pkg::DAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Datapath: partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[ctla_pkg::PROD_W-1:ctla_pkg::DAC_W];
            r_low <= i_dividend[ctla_pkg::DAC_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[ctla_pkg::STEP_W-1:0] : n_trial[ctla_pkg::STEP_W-1:0];
            r_low <= {r_low[ctla_pkg::DAC_W-2:0], n_ge};
        end
    end

    assign o_quotient    = r_low;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

// File: rtl/core/chime_tone_and_light_averager_unit.sv
// Doorbell chime tone generator and ambient light window averager, top level.
// A tick whose tone sample needs the taper divide runs through the tone, divide, light and
// done states after the request is accepted; any other tick skips the divide state.
// A new request is taken only once the previous one has left the done state.
// A finished result waits in the output register; the next request is taken meanwhile.
// Reset (synchronous, active low) restores register defaults and clears the tone and
// window state; the window memory needs no clearing, the fill count masks stale entries.
`include "chime_tone_and_light_averager_unit_assert.svh"

module chime_tone_and_light_averager_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ctla_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ctla_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    ctla_in_if.sink                             i_item,
    ctla_out_if.source                          o_result
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TONE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_LIGHT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // Configuration registers.
    logic [ctla_pkg::STEP_W-1:0] r_taper_steps;
    logic [ctla_pkg::LEN_W-1:0]  r_wave_length;
    logic [ctla_pkg::WORD_W-1:0] r_wave_word [4];
    logic [ctla_pkg::THR_W-1:0]  r_light_threshold;

    // Tone and window state.
    logic [2:0]                       r_state;
    logic                             r_button_seen;
    logic                             r_tone_one;
    logic                             r_tone_two;
    logic [ctla_pkg::COUNT_W-1:0]     r_taper_count;
    logic [ctla_pkg::WIDX_W-1:0]      r_wave_index;
    logic                             r_period_choice;
    logic [ctla_pkg::SLOT_W-1:0]      r_history_slot;
    logic [ctla_pkg::FILL_W-1:0]      r_fill_count;
    logic [ctla_pkg::SUM_W-1:0]       r_window_sum;
    logic                             r_led_level;
    logic [ctla_pkg::SAMPLE_BITS-1:0] r_sample;
    logic                             r_dac_write;
    logic [ctla_pkg::DAC_W-1:0]       r_dac_value;

    // Output register.
    logic                        r_out_valid;
    logic                        r_out_dac_write;
    logic [ctla_pkg::DAC_W-1:0]  r_out_dac_value;
    logic                        r_out_led_on;
    logic                        r_out_wait_select;

    logic                             in_take;
    logic                             tone_on;
    logic [ctla_pkg::WIDX_W-1:0]      n_slot;
    logic [ctla_pkg::WORD_W-1:0]      n_word;
    logic [ctla_pkg::COUNT_W-1:0]     n_count;
    logic                             n_scale_ok;
    logic [ctla_pkg::PROD_W-1:0]      n_product;
    logic                             div_start;
    logic [ctla_pkg::DAC_W-1:0]       div_quotient;
    ctla_pkg::t_div_status            div_status;
    logic                             ram_we;
    logic                             ram_re;
    logic [ctla_pkg::SAMPLE_BITS-1:0] ram_rdata;
    logic [ctla_pkg::SAMPLE_BITS-1:0] n_old;
    logic [ctla_pkg::SUM_W-1:0]       n_sum;
    logic [ctla_pkg::FILL_W-1:0]      n_fill;
    logic [ctla_pkg::SLOT_W-1:0]      n_next_slot;
    logic [ctla_pkg::CMP_W-1:0]       n_limit;
    logic                             out_free;

    assign in_take  = i_item.valid && i_item.ready;
    assign tone_on  = r_tone_one || r_tone_two;
    assign out_free = !r_out_valid || o_result.ready;

    // Tone sample setup: table slot, stepped taper count and the product to divide.
    always_comb begin
        n_slot     = ctla_pkg::wave_slot(r_wave_index, r_wave_length);
        n_word     = r_wave_word[n_slot];
        n_count    = r_taper_count + 1'b1;
        n_scale_ok = (r_taper_steps != '0) &&
                     (r_taper_count < ctla_pkg::COUNT_W'(r_taper_steps));
        n_product  = ctla_pkg::PROD_W'(n_word) *
                     ctla_pkg::PROD_W'(r_taper_steps - r_taper_count[ctla_pkg::STEP_W-1:0]);
        div_start  = (r_state == S_TONE) && tone_on && n_scale_ok;
    end

    // Window update: the sample replaces the oldest one; unfilled slots count as zero.
    always_comb begin
        n_old       = (r_fill_count < ctla_pkg::FILL_W'(ctla_pkg::WINDOW)) ? '0 : ram_rdata;
        n_sum       = r_window_sum + ctla_pkg::SUM_W'(r_sample) - ctla_pkg::SUM_W'(n_old);
        n_fill      = (r_fill_count < ctla_pkg::FILL_W'(ctla_pkg::WINDOW)) ?
                      r_fill_count + 1'b1 : r_fill_count;
        n_next_slot = (r_history_slot == ctla_pkg::SLOT_W'(ctla_pkg::WINDOW - 1)) ?
                      '0 : r_history_slot + 1'b1;
        n_limit     = ctla_pkg::CMP_W'(r_light_threshold) * ctla_pkg::CMP_W'(ctla_pkg::WINDOW);
        ram_re      = (r_state == S_TONE);
        ram_we      = (r_state == S_LIGHT) && !tone_on;
    end

    // Configuration write decoder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taper_steps     <= ctla_pkg::RST_TAPER_STEPS;
            r_wave_length     <= ctla_pkg::RST_WAVE_LENGTH;
            r_wave_word[0]    <= ctla_pkg::RST_WAVE_WORD_A;
            r_wave_word[1]    <= ctla_pkg::RST_WAVE_WORD_B;
            r_wave_word[2]    <= ctla_pkg::RST_WAVE_WORD_C;
            r_wave_word[3]    <= ctla_pkg::RST_WAVE_WORD_D;
            r_light_threshold <= ctla_pkg::RST_LIGHT_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ctla_pkg::CFG_TAPER_STEPS: begin
                    r_taper_steps <= i_cfg_data[ctla_pkg::STEP_W-1:0];
                end
                ctla_pkg::CFG_WAVE_LENGTH: begin
                    r_wave_length <= i_cfg_data[ctla_pkg::LEN_W-1:0];
                end
                ctla_pkg::CFG_WAVE_WORD_A: begin
                    r_wave_word[0] <= i_cfg_data[ctla_pkg::WORD_W-1:0];
                end
                ctla_pkg::CFG_WAVE_WORD_B: begin
                    r_wave_word[1] <= i_cfg_data[ctla_pkg::WORD_W-1:0];
                end
                ctla_pkg::CFG_WAVE_WORD_C: begin
                    r_wave_word[2] <= i_cfg_data[ctla_pkg::WORD_W-1:0];
                end
                ctla_pkg::CFG_WAVE_WORD_D: begin
                    r_wave_word[3] <= i_cfg_data[ctla_pkg::WORD_W-1:0];
                end
                ctla_pkg::CFG_LIGHT_THRESHOLD: begin
                    r_light_threshold <= i_cfg_data[ctla_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer: edge detect, tone step, serial divide, window update, hand-off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_button_seen   <= 1'b0;
            r_tone_one      <= 1'b0;
            r_tone_two      <= 1'b0;
            r_taper_count   <= '0;
            r_wave_index    <= '0;
            r_period_choice <= 1'b0;
            r_history_slot  <= '0;
            r_fill_count    <= '0;
            r_window_sum    <= '0;
            r_led_level     <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        // A press starts tone one, a release starts tone two.
                        if (i_item.button) begin
                            if (!r_button_seen) begin
                                if (!r_tone_one) begin
                                    r_taper_count <= '0;
                                end
                                r_button_seen <= 1'b1;
                                r_tone_one    <= 1'b1;
                                r_tone_two    <= 1'b0;
                            end
                        end else if (r_button_seen) begin
                            if (!r_tone_two) begin
                                r_taper_count <= '0;
                            end
                            r_button_seen <= 1'b0;
                            r_tone_one    <= 1'b0;
                            r_tone_two    <= 1'b1;
                        end
                        r_state <= S_TONE;
                    end
                end
                S_TONE: begin
                    if (tone_on) begin
                        r_period_choice <= !r_tone_one;
                        r_wave_index    <= n_slot + 1'b1;
                        r_taper_count   <= n_count;
                        // The tone ends once the stepped count passes the taper length.
                        if (n_count > ctla_pkg::COUNT_W'(r_taper_steps)) begin
                            if (r_tone_one) begin
                                r_tone_one <= 1'b0;
                            end else begin
                                r_tone_two <= 1'b0;
                            end
                        end
                        r_state <= n_scale_ok ? S_DIV : S_LIGHT;
                    end else begin
                        r_state <= S_LIGHT;
                    end
                end
                S_DIV: begin
                    if (div_status.done) begin
                        r_state <= S_LIGHT;
                    end
                end
                S_LIGHT: begin
                    if (!tone_on) begin
                        r_window_sum   <= n_sum;
                        r_fill_count   <= n_fill;
                        r_history_slot <= n_next_slot;
                        if (n_fill == ctla_pkg::FILL_W'(ctla_pkg::WINDOW)) begin
                            r_led_level <= (ctla_pkg::CMP_W'(n_sum) >= n_limit);
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result valid flag: set when a result is handed off, cleared once it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Per-item payload registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sample <= i_item.light_sample;
        end
        if (r_state == S_TONE) begin
            r_dac_write <= tone_on;
            r_dac_value <= '0;
        end else if ((r_state == S_DIV) && div_status.done) begin
            r_dac_value <= div_quotient;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_dac_write   <= r_dac_write;
            r_out_dac_value   <= r_dac_value;
            r_out_led_on      <= r_led_level;
            r_out_wait_select <= r_period_choice;
        end
    end

    // Shared serial divider for the taper scaling.
    ctla_taper_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_product),
        .i_divisor  (r_taper_steps),
        .o_quotient (div_quotient),
        .o_status   (div_status)
    );

    // Light sample history ring.
    ctla_ram #(
        .WIDTH (ctla_pkg::SAMPLE_BITS),
        .DEPTH (ctla_pkg::WINDOW)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_history_slot),
        .i_wdata (r_sample),
        .i_re    (ram_re),
        .i_raddr (r_history_slot),
        .o_rdata (ram_rdata)
    );

    assign i_item.ready          = (r_state == S_IDLE);
    assign o_result.valid        = r_out_valid;
    assign o_result.dac_write    = r_out_dac_write;
    assign o_result.dac_value    = r_out_dac_value;
    assign o_result.led_on       = r_out_led_on;
    assign o_result.wait_select  = r_out_wait_select;

    // Checks on the sequencer and datapath.
    `CTLA_ASSERT_IMP(a_fill_bounded, 1'b1, r_fill_count <= ctla_pkg::FILL_W'(ctla_pkg::WINDOW), "fill count above window")
    `CTLA_ASSERT_IMP(a_quiet_dac, o_result.valid && !o_result.dac_write, o_result.dac_value == '0, "dac value without write")
    `CTLA_ASSERT_NEXT(a_busy_after_take, in_take, !i_item.ready, "request taken while busy")
    `CTLA_ASSERT_IMP(a_div_in_seq, div_status.busy, r_state == S_DIV, "divider running outside divide state")

endmodule
